### rtl/core/cpd_pkg.sv
// Package for the CRC-16 packet deframer: result type, framing constants
// and the bytewise CRC-16/MCRF4XX update. No dependencies.
`timescale 1ns / 1ps

package cpd_pkg;

    // Framing constants.
    localparam logic [7:0]  SOP_BYTE    = 8'hA1;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [7:0]  MAX_LEN_RST = 8'hFF;

    // One result transaction.
    typedef struct packed {
        logic       has_payload;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic       packet_end;
        logic       crc_ok;
        logic [7:0] packet_type;
        logic [7:0] packet_length;
    } cpd_result_t;

    // Reflected CRC-16, polynomial 0x8408, one byte per call.
    function automatic logic [15:0] cpd_crc_step(input logic [7:0] data, input logic [15:0] crc);
        logic [7:0]  t;
        logic [15:0] t16;
        t   = data ^ crc[7:0];
        t   = t ^ {t[3:0], 4'h0};
        t16 = {8'h00, t};
        return {t, crc[15:8]} ^ (t16 >> 4) ^ (t16 << 3);
    endfunction

endpackage

### rtl/core/cpd_stream_if.sv
// Handshake interfaces for the deframer: the received byte stream and
// the result stream. Depends on cpd_pkg for nothing but keeps its order.
`timescale 1ns / 1ps

// Received byte channel.
interface cpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// Result channel, one field per signal.
interface cpd_result_if;
    logic       valid;
    logic       ready;
    logic       has_payload;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic       packet_end;
    logic       crc_ok;
    logic [7:0] packet_type;
    logic [7:0] packet_length;

    modport source (output valid, output has_payload, output payload_byte,
                    output byte_index, output packet_end, output crc_ok,
                    output packet_type, output packet_length, input ready);
    modport sink   (input valid, input has_payload, input payload_byte,
                    input byte_index, input packet_end, input crc_ok,
                    input packet_type, input packet_length, output ready);
endinterface

### rtl/core/cpd_input_reg.sv
// Input register of the deframer: holds one received byte until the
// framing logic takes it. Depends on cpd_byte_if.
`timescale 1ns / 1ps

module cpd_input_reg (
    input  logic       clk,
    input  logic       rst_n,
    cpd_byte_if.sink   stream,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // A new byte may enter when the register is empty or being drained.
    assign stream.ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (stream.ready)
        begin
            valid_next = stream.valid;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Byte holding register.
    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            data_reg <= stream.data_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

### rtl/core/cpd_frame_fsm.sv
// Framing state machine with the running CRC: parses start, type, length
// and CRC bytes and forms one result per payload byte or empty-packet end.
// Depends on cpd_pkg.
`timescale 1ns / 1ps

module cpd_frame_fsm
    import cpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        byte_valid,
    input  logic [7:0]  byte_data,
    output logic        take,
    input  logic        res_ready,
    output logic        res_valid,
    output cpd_result_t res_data
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_TYPE    = 3'd1;
    localparam logic [2:0] PH_LENGTH  = 3'd2;
    localparam logic [2:0] PH_CRC_LO  = 3'd3;
    localparam logic [2:0] PH_CRC_HI  = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    logic [7:0]  max_length_reg;
    logic [2:0]  phase_reg,         phase_next;
    logic [7:0]  type_reg,          type_next;
    logic [7:0]  length_reg,        length_next;
    logic [15:0] received_crc_reg,  received_crc_next;
    logic [15:0] running_crc_reg,   running_crc_next;
    logic [7:0]  payload_count_reg, payload_count_next;
    logic [15:0] crc_upd;
    logic [7:0]  count_inc;
    logic        last_byte;

    // A byte is consumed when the result register can take its result.
    assign take = byte_valid && res_ready;

    assign crc_upd   = cpd_crc_step(byte_data, running_crc_reg);
    assign count_inc = payload_count_reg + 8'd1;
    assign last_byte = (count_inc == length_reg);

    // Next state and result for the byte at the head; a result is only
    // offered while a byte is actually waiting.
    always_comb
    begin
        phase_next         = phase_reg;
        type_next          = type_reg;
        length_next        = length_reg;
        received_crc_next  = received_crc_reg;
        running_crc_next   = running_crc_reg;
        payload_count_next = payload_count_reg;
        res_valid          = 1'b0;
        res_data           = '0;
        res_data.packet_type   = type_reg;
        res_data.packet_length = length_reg;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (byte_data == SOP_BYTE)
                begin
                    running_crc_next   = CRC_INIT;
                    payload_count_next = 8'd0;
                    phase_next         = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                type_next        = byte_data;
                running_crc_next = crc_upd;
                phase_next       = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                // An oversized length aborts the packet.
                if (byte_data > max_length_reg)
                begin
                    phase_next = PH_HUNT;
                end
                else
                begin
                    length_next      = byte_data;
                    running_crc_next = crc_upd;
                    phase_next       = PH_CRC_LO;
                end
            end
            PH_CRC_LO:
            begin
                received_crc_next = {8'h00, byte_data};
                phase_next        = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                received_crc_next = {byte_data, received_crc_reg[7:0]};
                if (length_reg == 8'd0)
                begin
                    // Empty packet ends on the CRC high byte.
                    res_valid           = byte_valid;
                    res_data.packet_end = 1'b1;
                    res_data.crc_ok     = (running_crc_reg == received_crc_next);
                    phase_next          = PH_HUNT;
                end
                else
                begin
                    payload_count_next = 8'd0;
                    phase_next         = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                running_crc_next      = crc_upd;
                payload_count_next    = count_inc;
                res_valid             = byte_valid;
                res_data.has_payload  = 1'b1;
                res_data.payload_byte = byte_data;
                res_data.byte_index   = payload_count_reg;
                res_data.packet_end   = last_byte;
                res_data.crc_ok       = last_byte && (crc_upd == received_crc_reg);
                if (last_byte)
                begin
                    phase_next         = PH_HUNT;
                    payload_count_next = 8'd0;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LEN_RST;
        end
        else if (cfg_we)
        begin
            max_length_reg <= cfg_data;
        end
    end

    // Framing state, advanced once per consumed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT;
            type_reg          <= 8'd0;
            length_reg        <= 8'd0;
            received_crc_reg  <= 16'd0;
            running_crc_reg   <= CRC_INIT;
            payload_count_reg <= 8'd0;
        end
        else if (take)
        begin
            phase_reg         <= phase_next;
            type_reg          <= type_next;
            length_reg        <= length_next;
            received_crc_reg  <= received_crc_next;
            running_crc_reg   <= running_crc_next;
            payload_count_reg <= payload_count_next;
        end
    end

`ifndef SYNTHESIS
    // Results come only from the CRC high byte or from payload bytes.
    a_result_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (take && res_valid) |-> (phase_reg == PH_CRC_HI || phase_reg == PH_PAYLOAD))
        else $error("result produced outside CRC high or payload phase");

    // The payload counter stays below the packet length.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (payload_count_reg < length_reg))
        else $error("payload count reached packet length inside payload");

    // A completed packet sends the parser back to hunting.
    a_end_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (take && res_valid && res_data.packet_end) |=> (phase_reg == PH_HUNT))
        else $error("parser not hunting after packet end");
`endif

endmodule

### rtl/core/cpd_output_reg.sv
// Output register of the deframer: holds one result transaction until the
// consumer takes it. Depends on cpd_pkg and cpd_result_if.
`timescale 1ns / 1ps

module cpd_output_reg
    import cpd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_valid,
    input  cpd_result_t   res_data,
    output logic          res_ready,
    cpd_result_if.source  result
);

    logic        valid_reg;
    logic        valid_next;
    cpd_result_t data_reg;

    // Loadable when empty or when the held result leaves this cycle.
    assign res_ready = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_ready)
        begin
            valid_next = res_valid;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result holding register.
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            data_reg <= res_data;
        end
    end

    assign result.valid         = valid_reg;
    assign result.has_payload   = data_reg.has_payload;
    assign result.payload_byte  = data_reg.payload_byte;
    assign result.byte_index    = data_reg.byte_index;
    assign result.packet_end    = data_reg.packet_end;
    assign result.crc_ok        = data_reg.crc_ok;
    assign result.packet_type   = data_reg.packet_type;
    assign result.packet_length = data_reg.packet_length;

endmodule

### rtl/core/crc16_packet_deframer.sv
// Top level of the CRC-16 packet deframer: input register, framing state
// machine and output register. Depends on cpd_pkg and the stream interfaces.
//
//   channel   direction  payload
//   stream    in         data_byte
//   result    out        has_payload, payload_byte, byte_index, packet_end,
//                        crc_ok, packet_type, packet_length
//   cfg       in         cfg_we, cfg_data (max_length)
//
// One byte per cycle is sustained while the result side does not stall; a
// byte's result passes through the input register and then the output register.
// The CRC update and the framing decision are one byte-wide step per cycle while the result side does not stall.
// Reset clears both stages, sets the parser to hunting and max_length to 255.
// A stall on the result side fills the output register, then the input
// register, and only then drops stream.ready.
`timescale 1ns / 1ps

module crc16_packet_deframer
    import cpd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_data,
    cpd_byte_if.sink     stream,
    cpd_result_if.source result
);

    logic        take;
    logic        byte_valid;
    logic [7:0]  byte_data;
    logic        res_valid;
    logic        res_ready;
    cpd_result_t res_data;

    // Received byte register.
    cpd_input_reg u_input_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    // Framing and CRC check.
    cpd_frame_fsm u_frame_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .take       (take),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res_data   (res_data)
    );

    // Result register.
    cpd_output_reg u_output_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_ready (res_ready),
        .result    (result)
    );

endmodule
